>>> rtl/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg: shared types and constants of the centered mean filter
// Widths of the sample word, the delay-line geometry and the divider request.
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int YEAR_W       = 14;
  localparam int MONTH_W      = 4;
  localparam int HW_W         = 5;
  localparam int MAX_HW       = 31;
  localparam int NCELL        = 2 * MAX_HW + 1;
  localparam int IDX_W        = $clog2(NCELL + 1);
  localparam int SUM_W        = SAMPLE_W + IDX_W;
  localparam int CNT_W        = IDX_W;
  localparam int DIV_STEP_W   = $clog2(SUM_W + 1);

  localparam logic [HW_W-1:0]  HW_RESET  = HW_W'(1);
  localparam logic [IDX_W-1:0] SEEN_CAP  = IDX_W'(NCELL);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(NCELL - 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
  } cell_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

endpackage

>>> rtl/cmf_cell.sv
// ----------------------------------------------------------------------------
// cmf_cell: one stage of the sample delay line
// Takes the word of its newer neighbor on a shift, of its older one on a rotate.
// ----------------------------------------------------------------------------
module cmf_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          rot_i,
  input  cmf_pkg::cell_t from_newer_i,
  input  cmf_pkg::cell_t from_older_i,
  output cmf_pkg::cell_t q_o
);
  import cmf_pkg::*;

  cell_t cell_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= rot_i ? from_older_i : from_newer_i;
    end
  end

  assign q_o = cell_q;

endmodule

>>> rtl/cmf_div.sv
// ----------------------------------------------------------------------------
// cmf_div: restoring divider, one quotient bit per cycle
// Quotient holds after completion until the next start.
// ----------------------------------------------------------------------------
module cmf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmf_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [cmf_pkg::SUM_W-1:0] quo_o
);
  import cmf_pkg::*;

  logic [SUM_W-1:0]      quo_q, quo_d;
  logic [CNT_W:0]        rem_q, rem_d;
  logic [CNT_W-1:0]      dvs_q;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic                  busy_q, busy_d;
  logic [CNT_W:0]        rem_sh;
  logic                  fit;

  always_comb begin
    rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    fit    = rem_sh >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fit ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d  = {quo_q[SUM_W-2:0], fit};
      step_d = step_q + 1'b1;
      if (step_q == DIV_STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign done_o = !busy_q && !req_i.start;
  assign quo_o  = quo_q;

endmodule

>>> rtl/centered_mean_filter.sv
// ----------------------------------------------------------------------------
// centered_mean_filter: centered moving average over dated samples
// Emits the truncated mean of a shrinking-edge centered window per sample.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+--------------------------------
//  in       | in        | in_valid_i / in_stall_o | sample value, year, month, last
//  out      | out       | out_valid_o/out_stall_i | mean value, year, month, last
//  cfg      | in        | cfg_valid_i/cfg_ready_o | half_width (5 bits)
//
// An input word that causes no result leaves the filter idle. Each result
// rotates the delay line once around (sum over the window), then runs the
// serial divider, then loads the output register once it is free.
// A final word answers up to 32 results back to back.
// Reset clears control state and sets half_width to 1; the delay line is not
// cleared. A word waiting in the output register does not block input.
// ----------------------------------------------------------------------------
module centered_mean_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cmf_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  logic [cmf_pkg::YEAR_W-1:0]    sample_year_i,
  input  logic [cmf_pkg::MONTH_W-1:0]   sample_month_i,
  input  logic                          last_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cmf_pkg::SAMPLE_W-1:0]  mean_value_o,
  output logic [cmf_pkg::YEAR_W-1:0]    mean_year_o,
  output logic [cmf_pkg::MONTH_W-1:0]   mean_month_o,
  output logic                          last_out_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cmf_pkg::HW_W-1:0]      cfg_data_i
);
  import cmf_pkg::*;

  state_e state_q, state_d;

  logic [HW_W-1:0]  hw_q;
  logic [IDX_W-1:0] seen_q, seen_d;      // samples in current series
  logic [IDX_W-1:0] job_seen_q, job_seen_d;
  logic [HW_W-1:0]  back_q, back_d;      // centre of current result
  logic             flush_q, flush_d;
  logic [IDX_W-1:0] k_q, k_d;            // rotation step
  logic [SUM_W-1:0] acc_q, acc_d;
  cell_t            tag_q, tag_d;

  logic             out_valid_q;
  cell_t            out_q;
  logic             out_last_q;

  logic             accept;
  logic             out_free;
  logic             load_out;
  logic [IDX_W-1:0] seen_new;
  logic [IDX_W-1:0] reach;
  logic [IDX_W-1:0] far;
  logic [IDX_W-1:0] back_ext;

  cell_t            new_word;
  cell_t            cells [NCELL];
  logic             chain_en;
  logic             chain_rot;

  div_req_t         div_req;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // take the new half width when the host writes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hw_q <= cfg_data_i;
    end
  end

  // delay line: shift a new word in on accept, rotate once around per result
  assign new_word  = '{value: sample_value_i, year: sample_year_i, month: sample_month_i};
  assign chain_en  = accept || (state_q == ST_SUM);
  assign chain_rot = (state_q == ST_SUM);

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cmf_cell u_cell (
      .clk_i        (clk_i),
      .en_i         (chain_en),
      .rot_i        (chain_rot),
      .from_newer_i ((i == 0) ? new_word : cells[(i + NCELL - 1) % NCELL]),
      .from_older_i (cells[(i + 1) % NCELL]),
      .q_o          (cells[i])
    );
  end

  // window reaches back+h samples, clipped to the start of the series
  assign back_ext = IDX_W'(back_q);
  assign reach    = back_ext + IDX_W'(hw_q);
  assign far      = (reach > job_seen_q - 1'b1) ? job_seen_q - 1'b1 : reach;
  assign seen_new = (seen_q < SEEN_CAP) ? seen_q + 1'b1 : seen_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_DIV) && div_done && out_free;

  always_comb begin
    state_d    = state_q;
    seen_d     = seen_q;
    job_seen_d = job_seen_q;
    back_d     = back_q;
    flush_d    = flush_q;
    k_d        = k_q;
    acc_d      = acc_q;
    tag_d      = tag_q;
    div_req    = '{start: 1'b0, dividend: '0, divisor: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          job_seen_d = seen_new;
          k_d        = '0;
          acc_d      = '0;
          if (last_in_i) begin
            // flush: start at the oldest pending centre
            seen_d  = '0;
            flush_d = 1'b1;
            back_d  = (IDX_W'(hw_q) > seen_new - 1'b1) ? HW_W'(seen_new - 1'b1) : hw_q;
            state_d = ST_SUM;
          end else begin
            seen_d  = seen_new;
            flush_d = 1'b0;
            back_d  = hw_q;
            if (IDX_W'(hw_q) < seen_new) begin
              state_d = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        // cell 0 shows the word k samples back from the newest
        if (k_q <= far) begin
          acc_d = acc_q + SUM_W'(cells[0].value);
        end
        if (k_q == back_ext) begin
          tag_d = cells[0];
        end
        k_d = k_q + 1'b1;
        if (k_q == LAST_CELL) begin
          div_req = '{start: 1'b1, dividend: acc_d, divisor: far + 1'b1};
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (load_out) begin
          if (flush_q && back_q != '0) begin
            back_d  = back_q - 1'b1;
            k_d     = '0;
            acc_d   = '0;
            state_d = ST_SUM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      job_seen_q  <= '0;
      back_q      <= '0;
      flush_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      seen_q     <= seen_d;
      job_seen_q <= job_seen_d;
      back_q     <= back_d;
      flush_q    <= flush_d;
      k_q        <= k_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: accumulator, captured tag and output word
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    tag_q <= tag_d;
    if (load_out) begin
      out_q      <= '{value: div_quo[SAMPLE_W-1:0], year: tag_q.year, month: tag_q.month};
      out_last_q <= flush_q && (back_q == '0);
    end
  end

  cmf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = out_q.value;
  assign mean_year_o  = out_q.year;
  assign mean_month_o = out_q.month;
  assign last_out_o   = out_last_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the centered mean filter
// Drives dated sample series at random window widths, predicts every mean
// in a local model of the window and compares each output word in order.
// ----------------------------------------------------------------------------
module tb;
  import cmf_pkg::*;

  localparam int RING_N    = 2 * MAX_HW + 2;
  localparam int WDOG_MAX  = 200000;
  localparam int HOLD_LEN  = 600;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic                last;
  } mean_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] s_value = '0;
  logic [YEAR_W-1:0] s_year = '0;
  logic [MONTH_W-1:0] s_month = 4'd1;
  logic s_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SAMPLE_W-1:0] m_value;
  logic [YEAR_W-1:0] m_year;
  logic [MONTH_W-1:0] m_month;
  logic m_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [HW_W-1:0] cfg_data = '0;

  // Predictor state.
  logic [SAMPLE_W-1:0] win_value [RING_N];
  logic [YEAR_W-1:0]   win_year [RING_N];
  logic [MONTH_W-1:0]  win_month [RING_N];
  int unsigned win_pos = 0;
  int unsigned win_seen = 0;
  int unsigned cur_hw = 1;

  mean_word_t mean_queue[$];
  int errors = 0;
  int words_sent = 0;
  int means_checked = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  centered_mean_filter dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .sample_value_i(s_value), .sample_year_i(s_year),
    .sample_month_i(s_month), .last_in_i(s_last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .mean_value_o(m_value), .mean_year_o(m_year),
    .mean_month_o(m_month), .last_out_o(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  function automatic int unsigned slot_back(int unsigned back);
    return (win_pos + RING_N - (back % RING_N)) % RING_N;
  endfunction

  // Mean of the window whose centre lies 'back' words before the newest one.
  function automatic mean_word_t window_mean(int unsigned back, bit last);
    int unsigned far;
    longint unsigned total;
    mean_word_t w;
    far = back + cur_hw;
    if (far > win_seen - 1) far = win_seen - 1;
    total = 0;
    for (int unsigned d = 0; d <= far; d++) total += win_value[slot_back(d)];
    w.value = SAMPLE_W'(total / (far + 1));
    w.year  = win_year[slot_back(back)];
    w.month = win_month[slot_back(back)];
    w.last  = last;
    return w;
  endfunction

  // Advance the window by one sample and queue the means it releases.
  task automatic predict_means(logic [SAMPLE_W-1:0] v, logic [YEAR_W-1:0] y,
                               logic [MONTH_W-1:0] m, logic last);
    int unsigned back;
    win_pos = (win_pos + 1) % RING_N;
    win_value[win_pos] = v;
    win_year[win_pos] = y;
    win_month[win_pos] = m;
    if (win_seen < NCELL) win_seen++;
    if (last) begin
      back = cur_hw + 1;
      while (back > 0) begin
        back--;
        if (back < win_seen) mean_queue.push_back(window_mean(back, back == 0));
      end
      win_seen = 0;
    end else if (cur_hw < win_seen) begin
      mean_queue.push_back(window_mean(cur_hw, 1'b0));
    end
  endtask

  // Send one sample word, with a random gap before it. Valid drops at the
  // start of a gap or of a drain, so back-to-back words keep it high.
  task automatic send_sample(logic [SAMPLE_W-1:0] v, logic [YEAR_W-1:0] y,
                             logic [MONTH_W-1:0] m, logic last);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    s_value <= v;
    s_year <= y;
    s_month <= m;
    s_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_means(v, y, m, last);
    words_sent++;
  endtask

  task automatic drain_means();
    in_valid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_half_width(int unsigned hw);
    drain_means();
    cfg_valid <= 1'b1;
    cfg_data <= HW_W'(hw);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_hw = hw;
  endtask

  task automatic send_series(int n, bit noisy);
    for (int i = 0; i < n; i++) begin
      send_sample(noisy ? SAMPLE_W'($urandom) : SAMPLE_W'($urandom_range(0, 4095)),
                  YEAR_W'($urandom_range(0, 9999)), MONTH_W'($urandom_range(1, 12)),
                  i == n - 1);
    end
  endtask

  // Extremes of the sample and tag fields, short series, a lone sample.
  task automatic test_directed();
    send_sample('1, 14'd9999, 4'd12, 1'b0);
    send_sample('1, 14'd0, 4'd1, 1'b0);
    send_sample('0, 14'h3FFF, 4'hF, 1'b0);
    send_sample('1, 14'd0, 4'd0, 1'b0);
    send_sample(24'h000100, 14'd2000, 4'd6, 1'b1);
    send_sample(24'hABCDEF, 14'd1999, 4'd1, 1'b1);
    write_half_width(0);
    send_series(4, 1'b1);
    write_half_width(31);
    send_series(5, 1'b1);
  endtask

  // Random series at a sequence of widths, including both extremes.
  task automatic test_random_series();
    int unsigned widths [6] = '{2, 31, 0, 7, 1, 15};
    foreach (widths[k]) begin
      write_half_width(widths[k]);
      while (words_sent < 30 * (k + 1) + 20) begin
        send_series($urandom_range(1, 2 * widths[k] + 6), $urandom_range(0, 1));
      end
    end
  endtask

  // Hold the output off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    write_half_width(3);
    hold_off = 1'b1;
    send_series(20, 1'b1);
    hold_off = 1'b0;
    send_series(8, 1'b0);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_off && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      if (!hold_off) hold_cnt <= 0;
      if ($urandom_range(0, 19) == 0) begin
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted mean word against the oldest prediction.
  always @(posedge clk) begin
    mean_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_queue.size() == 0) begin
        $display("%0t: unexpected mean word value=%h year=%0d month=%0d last=%b",
                 $time, m_value, m_year, m_month, m_last);
        errors++;
      end else begin
        exp_w = mean_queue.pop_front();
        means_checked++;
        if (m_value !== exp_w.value) begin
          $display("%0t: mean_value expected %h actual %h", $time, exp_w.value, m_value);
          errors++;
        end
        if (m_year !== exp_w.year) begin
          $display("%0t: mean_year expected %0d actual %0d", $time, exp_w.year, m_year);
          errors++;
        end
        if (m_month !== exp_w.month) begin
          $display("%0t: mean_month expected %0d actual %0d", $time, exp_w.month, m_month);
          errors++;
        end
        if (m_last !== exp_w.last) begin
          $display("%0t: last_out expected %b actual %b", $time, exp_w.last, m_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("%0t: watchdog expired, %0d means outstanding", $time, mean_queue.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_series();
    test_backpressure();
    drain_means();
    $display("Covered %0d sample words and %0d mean words over widths 0 to 31,",
             words_sent, means_checked);
    $display("with random gaps, output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cmf_pkg.sv
rtl/cmf_cell.sv
rtl/cmf_div.sv
rtl/centered_mean_filter.sv
test/tb.sv
